>>> rtl/nscp_pkg.sv
package nscp_pkg;

   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_C = 8'h43;
   localparam logic [7:0] CH_UPPER_G = 8'h47;
   localparam logic [7:0] CH_UPPER_M = 8'h4D;
   localparam logic [7:0] CH_UPPER_S = 8'h53;
   localparam logic [7:0] CH_UPPER_T = 8'h54;
   localparam logic [7:0] CH_UPPER_V = 8'h56;

   localparam logic [31:0] IN_USE_MARK     = 32'h0000_0080;
   localparam logic [31:0] SNR_ALL_CLEAR   = 32'h0000_00FF;
   localparam logic [11:0] YEAR_BASE_RESET = 12'd2000;

   localparam logic [4:0] KIND_NONE     = 5'd0;
   localparam logic [4:0] KIND_FIX      = 5'd1;
   localparam logic [4:0] KIND_SATS     = 5'd2;
   localparam logic [4:0] KIND_ALT      = 5'd3;
   localparam logic [4:0] KIND_HR       = 5'd4;
   localparam logic [4:0] KIND_LAT      = 5'd7;
   localparam logic [4:0] KIND_NS       = 5'd8;
   localparam logic [4:0] KIND_LON      = 5'd9;
   localparam logic [4:0] KIND_EW       = 5'd10;
   localparam logic [4:0] KIND_SPEED    = 5'd11;
   localparam logic [4:0] KIND_COURSE   = 5'd12;
   localparam logic [4:0] KIND_DAY      = 5'd13;
   localparam logic [4:0] KIND_FIXTYPE  = 5'd16;
   localparam logic [4:0] KIND_SNR      = 5'd17;
   localparam logic [4:0] KIND_SNR_CLR  = 5'd18;
   localparam logic [4:0] KIND_POS_CLR  = 5'd19;

   localparam logic [2:0] TD_DAY = 3'd3;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_KEY,
      MODE_GGA,
      MODE_RMC,
      MODE_GSA,
      MODE_GSV,
      MODE_VTG
   } mode_type;

   typedef struct packed {
      logic [7:0]       kw0;
      logic [7:0]       kw1;
      logic [2:0]       cc;
      logic [4:0]       fi;
      logic             minus;
      logic [6:0]       sat;
      logic [6:0]       snr;
      logic [31:0]      num;
      logic [5:0][11:0] td;
      logic             fix;
   } datapath_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [4:0]  sat_index;
      logic [31:0] value;
      logic        ready;
      logic        fix;
   } result_type;

endpackage

>>> rtl/nmea_sentence_char_parser.sv
// NMEA 0183 sentence parser, one received character per item.
// req_ carries the character stream (req_rx_byte); rsp_ returns one result
// per character: which quantity it wrote (rsp_update_kind), the satellite
// entry for SNR and in-use updates, the new value, the data ready pulse that
// follows a VTG address and the current fix flag.
// Both channels move an item when valid is high and stall is low.
// The character is held in an input register, decoded in one pass against
// the parser state, and the result lands in an output register. One item is
// taken every cycle while the receiver does not stall; the rate is set by the
// state update between the two registers.
// When the receiver stalls, the result holds in the output register and one
// more character may wait in the input register before req_stall rises.
// The csr_ port writes year_base (added to the two-digit year); csr_ready
// is always high and writes are expected only while the block is idle.
// Synchronous reset empties both registers, puts the parser in idle,
// clears all accumulators and the fix flag, and sets year_base to 2000.
module nmea_sentence_char_parser #(
   parameter int NUM_SATS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [4:0]         rsp_update_kind,
   output logic [4:0]         rsp_sat_index,
   output logic signed [31:0] rsp_update_value,
   output logic               rsp_data_ready,
   output logic               rsp_fix_valid,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [11:0]        csr_year_base
);
   import nscp_pkg::*;

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       out_vld_ff, out_vld_in;
   result_type out_ff, out_in;
   result_type step_res;
   logic       advance, req_take, rsp_take;

   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = out_vld_ff && !rsp_stall;
   assign csr_ready = 1'b1;

   nscp_core #(
      .NUM_SATS(NUM_SATS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .rx_byte       (in_byte_ff),
      .cfg_we        (csr_valid && csr_ready),
      .cfg_year_base (csr_year_base),
      .res           (step_res)
   );

   always_comb begin
      in_vld_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
      in_byte_in = req_take ? req_rx_byte : in_byte_ff;
      out_vld_in = advance ? 1'b1 : (rsp_take ? 1'b0 : out_vld_ff);
      out_in     = advance ? step_res : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_update_kind  = out_ff.kind;
   assign rsp_sat_index    = out_ff.sat_index;
   assign rsp_update_value = $signed(out_ff.value);
   assign rsp_data_ready   = out_ff.ready;
   assign rsp_fix_valid    = out_ff.fix;

endmodule

>>> rtl/nscp_core.sv
module nscp_core #(
   parameter int NUM_SATS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [7:0]          rx_byte,
   input  logic                cfg_we,
   input  logic [11:0]         cfg_year_base,
   output nscp_pkg::result_type res
);
   import nscp_pkg::*;

   localparam logic [6:0] SAT_MAX = 7'(NUM_SATS);

   mode_type     mode_ff, mode_in;
   datapath_type dp_ff, dp_in;
   logic [11:0]  year_base_ff, year_base_in;

   logic [31:0] d32, acc10;
   logic [11:0] d12;
   logic [6:0]  d7, sat10, snr10;
   logic [2:0]  cc_inc;
   logic [7:0]  kw0_new, kw1_new;

   assign d32     = {24'd0, rx_byte} - {24'd0, CH_ZERO};
   assign d12     = {4'd0, rx_byte} - {4'd0, CH_ZERO};
   assign d7      = rx_byte[6:0] - CH_ZERO[6:0];
   assign acc10   = (dp_ff.num << 3) + (dp_ff.num << 1);
   assign sat10   = (dp_ff.sat << 3) + (dp_ff.sat << 1);
   assign snr10   = (dp_ff.snr << 3) + (dp_ff.snr << 1);
   assign cc_inc  = (dp_ff.cc == 3'd7) ? 3'd7 : dp_ff.cc + 3'd1;
   assign kw0_new = (dp_ff.cc == 3'd3) ? rx_byte : dp_ff.kw0;
   assign kw1_new = (dp_ff.cc == 3'd4) ? rx_byte : dp_ff.kw1;
   assign year_base_in = cfg_we ? cfg_year_base : year_base_ff;

   function automatic logic sat_ok(logic [6:0] s);
      return (s != 7'd0) && (s <= SAT_MAX);
   endfunction

   // First digit sets tens, second adds units (plus the century for the year).
   function automatic logic [11:0] td_next(logic [11:0] old, logic [11:0] d,
                                           logic second, logic is_year,
                                           logic [11:0] base);
      logic [11:0] v;
      if (second) begin
         v = old + d + (is_year ? base : 12'd0);
      end else begin
         v = (d << 3) + (d << 1);
      end
      return v;
   endfunction

   // Next parse mode
   always_comb begin
      mode_in = mode_ff;
      if (rx_byte == CH_CR) begin
         mode_in = MODE_IDLE;
      end else begin
         unique case (mode_ff) inside
            MODE_KEY: begin
               if (cc_inc == 3'd5) begin
                  if (kw0_new == CH_UPPER_G && kw1_new == CH_UPPER_A)
                     mode_in = MODE_GGA;
                  else if (kw0_new == CH_UPPER_M && kw1_new == CH_UPPER_C)
                     mode_in = MODE_RMC;
                  else if (kw0_new == CH_UPPER_S && kw1_new == CH_UPPER_A)
                     mode_in = MODE_GSA;
                  else if (kw0_new == CH_UPPER_S && kw1_new == CH_UPPER_V)
                     mode_in = MODE_GSV;
                  else if (kw0_new == CH_UPPER_T && kw1_new == CH_UPPER_G)
                     mode_in = MODE_VTG;
                  else
                     mode_in = MODE_IDLE;
               end
            end
            MODE_VTG: begin
               mode_in = MODE_IDLE;
            end
            MODE_GGA, MODE_RMC, MODE_GSA, MODE_GSV: begin
               if (rx_byte == CH_LF || rx_byte == CH_STAR)
                  mode_in = MODE_IDLE;
               else if (mode_ff == MODE_RMC && rx_byte != CH_COMMA &&
                        dp_ff.fi == 5'd2 && rx_byte != CH_UPPER_A)
                  mode_in = MODE_IDLE;
            end
            default: begin
               mode_in = (rx_byte == CH_DOLLAR) ? MODE_KEY : MODE_IDLE;
            end
         endcase
      end
   end

   // Field accumulators and the result of this byte
   always_comb begin
      logic [1:0]  slot;
      logic [2:0]  idx;
      logic [11:0] tdv;
      logic [6:0]  s;
      dp_in = dp_ff;
      res = '0;
      res.kind = KIND_NONE;
      slot = dp_ff.cc[2:1];
      idx = {1'b0, slot};
      tdv = '0;
      s = '0;
      if (rx_byte != CH_CR) begin
         unique case (mode_ff) inside
            MODE_KEY: begin
               dp_in.kw0 = kw0_new;
               dp_in.kw1 = kw1_new;
               dp_in.cc = cc_inc;
               if (cc_inc == 3'd5) begin
                  dp_in.num = '0;
                  dp_in.cc = '0;
                  dp_in.minus = 1'b0;
                  dp_in.fi = '0;
               end
            end
            MODE_VTG: begin
               res.ready = 1'b1;
            end
            MODE_GGA, MODE_RMC, MODE_GSA, MODE_GSV: begin
               if (rx_byte == CH_LF || rx_byte == CH_STAR) begin
                  // sentence ends, nothing written
               end else if (rx_byte == CH_COMMA) begin
                  if (dp_ff.fi != 5'd31)
                     dp_in.fi = dp_ff.fi + 5'd1;
                  dp_in.num = '0;
                  dp_in.cc = '0;
                  dp_in.minus = 1'b0;
               end else if (mode_ff == MODE_GGA) begin
                  case (dp_ff.fi)
                     5'd6: begin
                        dp_in.fix = (rx_byte == CH_ONE);
                        res.kind = KIND_FIX;
                        res.value = {31'd0, dp_in.fix};
                     end
                     5'd7: begin
                        if (rx_byte != CH_DOT) begin
                           dp_in.num = acc10 + d32;
                           res.kind = KIND_SATS;
                           res.value = dp_in.num;
                           dp_in.cc = cc_inc;
                        end
                     end
                     5'd9: begin
                        if (rx_byte == CH_MINUS) begin
                           dp_in.minus = 1'b1;
                        end else if (rx_byte != CH_DOT) begin
                           dp_in.num = dp_ff.minus ? acc10 - d32 : acc10 + d32;
                           res.kind = KIND_ALT;
                           res.value = dp_in.num;
                        end
                     end
                     default: ;
                  endcase
               end else if (mode_ff == MODE_RMC) begin
                  case (dp_ff.fi) inside
                     5'd1: begin
                        if (dp_ff.cc < 3'd6) begin
                           tdv = td_next(dp_ff.td[idx], d12, dp_ff.cc[0], 1'b0,
                                         year_base_ff);
                           dp_in.td[idx] = tdv;
                           res.kind = KIND_HR + {3'd0, slot};
                           res.value = {20'd0, tdv};
                        end
                        dp_in.cc = cc_inc;
                     end
                     5'd2: begin
                        dp_in.num = '0;
                        res.kind = KIND_POS_CLR;
                     end
                     5'd3, 5'd5, 5'd7: begin
                        if (rx_byte != CH_DOT) begin
                           dp_in.num = acc10 + d32;
                           res.value = dp_in.num;
                           if (dp_ff.fi == 5'd3)
                              res.kind = KIND_LAT;
                           else if (dp_ff.fi == 5'd5)
                              res.kind = KIND_LON;
                           else
                              res.kind = KIND_SPEED;
                        end
                     end
                     5'd4, 5'd6: begin
                        res.kind = (dp_ff.fi == 5'd4) ? KIND_NS : KIND_EW;
                        res.value = {24'd0, rx_byte};
                     end
                     5'd8: begin
                        // point closes the integer part: no more course digits
                        if (rx_byte == CH_DOT) begin
                           dp_in.cc = 3'd5;
                        end else begin
                           if (dp_ff.cc < 3'd3) begin
                              dp_in.num = acc10 + d32;
                              res.kind = KIND_COURSE;
                              res.value = dp_in.num;
                           end
                           dp_in.cc = cc_inc;
                        end
                     end
                     5'd9: begin
                        if (dp_ff.cc < 3'd6) begin
                           idx = TD_DAY + {1'b0, slot};
                           tdv = td_next(dp_ff.td[idx], d12, dp_ff.cc[0],
                                         slot == 2'd2, year_base_ff);
                           dp_in.td[idx] = tdv;
                           res.kind = KIND_DAY + {3'd0, slot};
                           res.value = {20'd0, tdv};
                        end
                        dp_in.cc = cc_inc;
                     end
                     default: ;
                  endcase
               end else if (mode_ff == MODE_GSA) begin
                  case (dp_ff.fi) inside
                     5'd1: begin
                        res.kind = KIND_SNR_CLR;
                        res.value = SNR_ALL_CLEAR;
                     end
                     5'd2: begin
                        res.kind = KIND_FIXTYPE;
                        res.value = d32;
                     end
                     [5'd3:5'd14]: begin
                        if (dp_ff.cc == 3'd0) begin
                           dp_in.sat = d7;
                        end else if (dp_ff.cc == 3'd1) begin
                           s = sat10 + d7;
                           dp_in.sat = s;
                           if (sat_ok(s)) begin
                              res.kind = KIND_SNR;
                              res.sat_index = 5'(s - 7'd1);
                              res.value = IN_USE_MARK;
                           end
                        end
                        dp_in.cc = cc_inc;
                     end
                     default: ;
                  endcase
               end else begin
                  if (dp_ff.fi == 5'd1) begin
                     dp_in.sat = '0;
                     dp_in.snr = '0;
                  end else if (dp_ff.fi >= 5'd4 && dp_ff.fi <= 5'd19 &&
                               dp_ff.fi[1:0] == 2'd0) begin
                     if (dp_ff.cc == 3'd0) begin
                        dp_in.sat = d7;
                        dp_in.snr = '0;
                     end else if (dp_ff.cc == 3'd1) begin
                        s = sat10 + d7;
                        dp_in.sat = s;
                        if (sat_ok(s)) begin
                           res.kind = KIND_SNR;
                           res.sat_index = 5'(s - 7'd1);
                           res.value = {25'd0, dp_ff.snr};
                        end
                     end
                     dp_in.cc = cc_inc;
                  end else if (dp_ff.fi >= 5'd7 && dp_ff.fi <= 5'd19 &&
                               dp_ff.fi[1:0] == 2'd3) begin
                     if (dp_ff.cc == 3'd0) begin
                        dp_in.snr = d7;
                     end else if (dp_ff.cc == 3'd1) begin
                        s = snr10 + d7;
                        dp_in.snr = s;
                        if (sat_ok(dp_ff.sat)) begin
                           res.kind = KIND_SNR;
                           res.sat_index = 5'(dp_ff.sat - 7'd1);
                           res.value = {25'd0, s};
                        end
                     end
                     dp_in.cc = cc_inc;
                  end
               end
            end
            default: begin
               if (rx_byte == CH_DOLLAR)
                  dp_in.cc = '0;
            end
         endcase
      end
      res.fix = dp_in.fix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         dp_ff <= '0;
         year_base_ff <= YEAR_BASE_RESET;
      end else begin
         year_base_ff <= year_base_in;
         if (step_en) begin
            mode_ff <= mode_in;
            dp_ff <= dp_in;
         end
      end
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import nscp_pkg::*;

   localparam int NUM_SATS = 32;
   localparam logic [2:0] TD_YEAR = TD_DAY + 3'd2;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = 8'd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [4:0]         rsp_update_kind;
   logic [4:0]         rsp_sat_index;
   logic signed [31:0] rsp_update_value;
   logic               rsp_data_ready;
   logic               rsp_fix_valid;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [11:0]        csr_year_base = 12'd0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int errors = 0;
   int sentence_chars = 0;

   result_type pending_updates[$];
   result_type want;
   logic [7:0] line_buf[$];

   // parser state as the block should hold it
   mode_type    pm_mode = MODE_IDLE;
   logic [7:0]  pm_kw[2] = '{8'd0, 8'd0};
   logic [2:0]  pm_count = 3'd0;
   logic [4:0]  pm_field = 5'd0;
   logic        pm_minus = 1'b0;
   logic [6:0]  pm_sat = 7'd0;
   logic [6:0]  pm_snr = 7'd0;
   logic [31:0] pm_num = 32'd0;
   logic [11:0] pm_td[6] = '{default: 12'd0};
   logic        pm_fix = 1'b0;
   logic [11:0] pm_year_base = YEAR_BASE_RESET;

   nmea_sentence_char_parser #(
      .NUM_SATS(NUM_SATS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_update_kind(rsp_update_kind),
      .rsp_sat_index(rsp_sat_index),
      .rsp_update_value(rsp_update_value),
      .rsp_data_ready(rsp_data_ready),
      .rsp_fix_valid(rsp_fix_valid),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_year_base(csr_year_base)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_stall_pct);
   end

   function automatic void bump_count();
      if (pm_count < 3'd7) begin
         pm_count = pm_count + 3'd1;
      end
   endfunction

   function automatic void field_start();
      pm_num = 32'd0;
      pm_count = 3'd0;
      pm_minus = 1'b0;
   endfunction

   function automatic logic [6:0] decimal7(input logic [6:0] acc, input logic [31:0] d);
      logic [31:0] t;
      t = {25'd0, acc} * 32'd10 + d;
      return t[6:0];
   endfunction

   // first digit of a pair times ten, second added (year also gets the base)
   function automatic logic [11:0] two_digit(input logic [2:0] slot, input logic [31:0] d,
                                             input logic second);
      logic [31:0] v;
      v = second ? {20'd0, pm_td[slot]} + d : d * 32'd10;
      if (second && slot == TD_YEAR) begin
         v = v + {20'd0, pm_year_base};
      end
      pm_td[slot] = v[11:0];
      return v[11:0];
   endfunction

   function automatic result_type sat_update(input logic [31:0] v);
      result_type r;
      logic [6:0] idx;
      r = '0;
      if (pm_sat >= 7'd1 && pm_sat <= 7'(NUM_SATS)) begin
         idx = pm_sat - 7'd1;
         r.kind = KIND_SNR;
         r.sat_index = idx[4:0];
         r.value = v;
      end
      return r;
   endfunction

   function automatic result_type decode_char(input logic [7:0] ch);
      result_type r;
      logic [31:0] d;
      logic [2:0] c;
      logic [4:0] f;
      d = {24'd0, ch} - {24'd0, CH_ZERO};
      c = pm_count;
      f = pm_field;
      r = '0;
      if (ch == CH_CR) begin
         pm_mode = MODE_IDLE;
      end else if (pm_mode == MODE_KEY) begin
         if (c == 3'd3) begin
            pm_kw[0] = ch;
         end else if (c == 3'd4) begin
            pm_kw[1] = ch;
         end
         bump_count();
         if (pm_count == 3'd5) begin
            if (pm_kw[0] == CH_UPPER_G && pm_kw[1] == CH_UPPER_A) pm_mode = MODE_GGA;
            else if (pm_kw[0] == CH_UPPER_M && pm_kw[1] == CH_UPPER_C) pm_mode = MODE_RMC;
            else if (pm_kw[0] == CH_UPPER_S && pm_kw[1] == CH_UPPER_A) pm_mode = MODE_GSA;
            else if (pm_kw[0] == CH_UPPER_S && pm_kw[1] == CH_UPPER_V) pm_mode = MODE_GSV;
            else if (pm_kw[0] == CH_UPPER_T && pm_kw[1] == CH_UPPER_G) pm_mode = MODE_VTG;
            else pm_mode = MODE_IDLE;
            field_start();
            pm_field = 5'd0;
         end
      end else if (pm_mode == MODE_VTG) begin
         r.ready = 1'b1;
         pm_mode = MODE_IDLE;
      end else if (pm_mode == MODE_GGA || pm_mode == MODE_RMC || pm_mode == MODE_GSA ||
                   pm_mode == MODE_GSV) begin
         if (ch == CH_LF || ch == CH_STAR) begin
            pm_mode = MODE_IDLE;
         end else if (ch == CH_COMMA) begin
            if (f < 5'd31) begin
               pm_field = f + 5'd1;
            end
            field_start();
         end else begin
            case (pm_mode)
               MODE_GGA: begin
                  if (f == 5'd6) begin
                     pm_fix = (ch == CH_ONE);
                     r.kind = KIND_FIX;
                     r.value = {31'd0, pm_fix};
                  end else if (f == 5'd7 && ch != CH_DOT) begin
                     pm_num = pm_num * 32'd10 + d;
                     r.kind = KIND_SATS;
                     r.value = pm_num;
                     bump_count();
                  end else if (f == 5'd9) begin
                     if (ch == CH_MINUS) begin
                        pm_minus = 1'b1;
                     end else if (ch != CH_DOT) begin
                        pm_num = pm_minus ? pm_num * 32'd10 - d : pm_num * 32'd10 + d;
                        r.kind = KIND_ALT;
                        r.value = pm_num;
                     end
                  end
               end
               MODE_RMC: begin
                  case (f)
                     5'd1: begin
                        if (c < 3'd6) begin
                           r.value = {20'd0, two_digit({1'b0, c[2:1]}, d, c[0])};
                           r.kind = KIND_HR + {3'd0, c[2:1]};
                        end
                        bump_count();
                     end
                     5'd2: begin
                        // anything but an active status drops the sentence
                        if (ch != CH_UPPER_A) begin
                           pm_mode = MODE_IDLE;
                        end
                        pm_num = 32'd0;
                        r.kind = KIND_POS_CLR;
                     end
                     5'd3, 5'd5, 5'd7: begin
                        if (ch != CH_DOT) begin
                           pm_num = pm_num * 32'd10 + d;
                           r.kind = (f == 5'd3) ? KIND_LAT : (f == 5'd5) ? KIND_LON : KIND_SPEED;
                           r.value = pm_num;
                        end
                     end
                     5'd4, 5'd6: begin
                        r.kind = (f == 5'd4) ? KIND_NS : KIND_EW;
                        r.value = {24'd0, ch};
                     end
                     5'd8: begin
                        // integer part of the course only, three digits at most
                        if (ch == CH_DOT) begin
                           pm_count = 3'd4;
                        end else if (c < 3'd3) begin
                           pm_num = pm_num * 32'd10 + d;
                           r.kind = KIND_COURSE;
                           r.value = pm_num;
                        end
                        bump_count();
                     end
                     5'd9: begin
                        if (c < 3'd6) begin
                           r.value = {20'd0, two_digit(TD_DAY + {1'b0, c[2:1]}, d, c[0])};
                           r.kind = KIND_DAY + {3'd0, c[2:1]};
                        end
                        bump_count();
                     end
                     default: ;
                  endcase
               end
               MODE_GSA: begin
                  if (f == 5'd1) begin
                     r.kind = KIND_SNR_CLR;
                     r.value = SNR_ALL_CLEAR;
                  end else if (f == 5'd2) begin
                     r.kind = KIND_FIXTYPE;
                     r.value = d;
                  end else if (f >= 5'd3 && f <= 5'd14) begin
                     if (c == 3'd0) begin
                        pm_sat = d[6:0];
                     end else if (c == 3'd1) begin
                        pm_sat = decimal7(pm_sat, d);
                        r = sat_update(IN_USE_MARK);
                     end
                     bump_count();
                  end
               end
               MODE_GSV: begin
                  if (f == 5'd1) begin
                     pm_sat = 7'd0;
                     pm_snr = 7'd0;
                  end else if (f >= 5'd4 && f <= 5'd19 && f[1:0] == 2'd0) begin
                     if (c == 3'd0) begin
                        pm_sat = d[6:0];
                        pm_snr = 7'd0;
                     end else if (c == 3'd1) begin
                        pm_sat = decimal7(pm_sat, d);
                        r = sat_update({25'd0, pm_snr});
                     end
                     bump_count();
                  end else if (f >= 5'd7 && f <= 5'd19 && f[1:0] == 2'd3) begin
                     if (c == 3'd0) begin
                        pm_snr = d[6:0];
                     end else if (c == 3'd1) begin
                        pm_snr = decimal7(pm_snr, d);
                        r = sat_update({25'd0, pm_snr});
                     end
                     bump_count();
                  end
               end
               default: ;
            endcase
         end
      end else begin
         if (ch == CH_DOLLAR) begin
            pm_mode = MODE_KEY;
            pm_count = 3'd0;
         end else begin
            pm_mode = MODE_IDLE;
         end
      end
      r.fix = pm_fix;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act);
      if (act !== exp_v) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_updates.size() == 0) begin
            $display("%0t: result with nothing pending, kind %0d value %0h", $time,
                     rsp_update_kind, rsp_update_value);
            errors++;
         end else begin
            want = pending_updates.pop_front();
            check_field("update_kind", {27'd0, want.kind}, {27'd0, rsp_update_kind});
            check_field("sat_index", {27'd0, want.sat_index}, {27'd0, rsp_sat_index});
            check_field("update_value", want.value, rsp_update_value);
            check_field("data_ready", {31'd0, want.ready}, {31'd0, rsp_data_ready});
            check_field("fix_valid", {31'd0, want.fix}, {31'd0, rsp_fix_valid});
         end
      end
   end

   task automatic send_char(input logic [7:0] ch);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_updates.push_back(decode_char(ch));
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic drain_updates();
      req_valid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_year_base(input logic [11:0] v);
      drain_updates();
      csr_valid <= 1'b1;
      csr_year_base <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      pm_year_base = v;
   endtask

   function automatic int vary(input int typ, input int lo, input int hi);
      if ($urandom_range(0, 4) != 0) return typ;
      return int'($urandom_range(0, hi - lo)) + lo;
   endfunction

   function automatic void put_ch(input logic [7:0] ch);
      line_buf.push_back(ch);
   endfunction

   function automatic void put_str(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   function automatic void put_digit(input int lo, input int hi);
      line_buf.push_back(8'(CH_ZERO + $urandom_range(lo, hi)));
   endfunction

   // ni integer digits, then a point and nf digits unless nf is negative
   function automatic void put_num(input int ni, input int nf);
      repeat (ni) put_digit(0, 9);
      if (nf >= 0) begin
         put_ch(CH_DOT);
         repeat (nf) put_digit(0, 9);
      end
   endfunction

   // open a field, now and then with a stray byte up front
   function automatic void next_field();
      put_ch(CH_COMMA);
      if ($urandom_range(0, 15) == 0) put_ch(8'($urandom_range(0, 255)));
   endfunction

   function automatic void put_sat_id();
      int id;
      id = $urandom_range(0, 39);
      if ($urandom_range(0, 9) == 0) begin
         put_num($urandom_range(1, 3), -1);
      end else begin
         put_digit(id / 10, id / 10);
         put_digit(id % 10, id % 10);
      end
   endfunction

   function automatic void build_sentence();
      int sel;
      int n;
      line_buf = {};
      put_ch(CH_DOLLAR);
      put_str($urandom_range(0, 1) ? "GP" : "GN");
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1: begin
            put_str("GGA");
            next_field(); put_num(vary(6, 0, 8), vary(2, -1, 3));
            next_field(); put_num(4, 4);
            next_field(); put_str($urandom_range(0, 1) ? "N" : "S");
            next_field(); put_num(5, 4);
            next_field(); put_str($urandom_range(0, 1) ? "E" : "W");
            next_field(); put_digit(0, 2);
            next_field(); put_num(vary(2, 0, 4), vary(-1, -1, 2));
            next_field(); put_num(1, 1);
            next_field();
            if ($urandom_range(0, 2) == 0) put_ch(CH_MINUS);
            put_num($urandom_range(0, 9) == 0 ? $urandom_range(9, 14) : $urandom_range(0, 4),
                    vary(1, -1, 3));
            next_field(); put_str("M");
            next_field(); put_num(2, 1);
            next_field(); put_str("M");
            next_field();
            next_field();
         end
         2, 3: begin
            put_str("RMC");
            next_field(); put_num(vary(6, 0, 9), vary(2, -1, 3));
            next_field();
            if ($urandom_range(0, 19) != 0) begin
               put_ch($urandom_range(0, 9) != 0 ? CH_UPPER_A : 8'($urandom_range(0, 255)));
            end
            next_field(); put_num(vary(4, 0, 12), vary(4, -1, 6));
            next_field(); put_str($urandom_range(0, 1) ? "N" : "S");
            next_field(); put_num(vary(5, 0, 12), vary(4, -1, 6));
            next_field(); put_str($urandom_range(0, 1) ? "E" : "W");
            next_field(); put_num(vary(3, 0, 6), vary(1, -1, 3));
            next_field(); put_num(vary(3, 0, 5), vary(1, -1, 2));
            next_field(); put_num(vary(6, 0, 8), -1);
            next_field(); put_num(vary(3, 0, 4), 1);
            next_field(); put_str($urandom_range(0, 1) ? "E" : "W");
            next_field(); put_str("A");
         end
         4, 5: begin
            put_str("GSA");
            next_field(); put_str($urandom_range(0, 1) ? "A" : "M");
            next_field();
            if ($urandom_range(0, 9) != 0) put_digit(1, 3);
            else put_ch(8'($urandom_range(0, 255)));
            for (int i = 3; i <= 14; i++) begin
               next_field();
               if ($urandom_range(0, 2) != 0) put_sat_id();
            end
            repeat (3) begin
               next_field(); put_num(1, 1);
            end
         end
         6, 7: begin
            put_str("GSV");
            next_field(); put_digit(1, 4);
            next_field(); put_digit(1, 4);
            next_field(); put_num(2, -1);
            n = $urandom_range(0, 4);
            repeat (n) begin
               next_field(); put_sat_id();
               next_field(); put_num(vary(2, 0, 3), -1);
               next_field(); put_num(vary(3, 0, 3), -1);
               next_field();
               if ($urandom_range(0, 4) != 0) put_num(vary(2, 0, 3), -1);
            end
            // run the field index up, at times into its ceiling
            if ($urandom_range(0, 7) == 0) begin
               repeat ($urandom_range(10, 30)) begin
                  next_field(); put_num($urandom_range(0, 2), -1);
               end
            end
         end
         8: begin
            put_str("VTG");
            next_field(); put_num(3, 1);
            next_field(); put_str("T");
         end
         default: begin
            repeat (3) put_ch(8'($urandom_range(8'h41, 8'h5A)));
            next_field(); put_num(3, 1);
         end
      endcase
      sel = $urandom_range(0, 9);
      if (sel <= 5) begin
         put_ch(CH_STAR);
         put_digit(0, 9);
         put_digit(0, 9);
         put_ch(CH_CR);
         put_ch(CH_LF);
      end else if (sel <= 7) begin
         put_ch(CH_LF);
      end else if (sel == 8) begin
         put_ch(CH_CR);
         put_ch(CH_LF);
      end
   endfunction

   task automatic test_gga_fields();
      send_text("$GPGGA,,,,,,1,1.2,,-9.5*");
      send_text("$GNGGA,,,,,,0,,,12345678901");
      send_char(CH_CR);
   endtask

   // date is read with the year base still at its reset value
   task automatic test_rmc_fields();
      send_text("$GPRMC,235959.9,V,1");
      send_char(CH_CR);
      send_text("$GPRMC,,A,12.5,S,7,W,0.,1234.5,311299,x*");
   endtask

   task automatic test_gsa_in_use();
      send_text("$GNGSA,A,3,00,01,32,33,7");
      send_char(CH_LF);
   endtask

   task automatic test_gsv_snr();
      send_text("$GPGSV,1,1,4,07,1,2,45,32,,,9");
      send_char(CH_CR);
   endtask

   task automatic test_vtg_and_framing();
      send_text("$GPVTG,1$GPXYZ,1$GPGGA,,,,,,");
      send_char(CH_CR);
      send_text("1");
      send_char(8'h00);
      send_char(8'hFF);
   endtask

   task automatic test_random_traffic(input logic [11:0] year, input int idle_pct,
                                      input int stall_pct, input int target);
      int start;
      write_year_base(year);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      start = sentence_chars;
      while (sentence_chars - start < target) begin
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)));
         end
         build_sentence();
         foreach (line_buf[i]) send_char(line_buf[i]);
         sentence_chars += line_buf.size();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_gga_fields();
      test_rmc_fields();
      test_gsa_in_use();
      test_gsv_snr();
      test_vtg_and_framing();
      test_random_traffic(12'd0, 0, 0, 210);
      test_random_traffic(12'hFFF, 76, 0, 210);
      test_random_traffic(12'($urandom_range(0, 4095)), 0, 76, 210);
      test_random_traffic(YEAR_BASE_RESET, 37, 37, 210);
      drain_updates();
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
